>>> sv/jbsp_pkg.sv
// ----------------------------------------------------------------------------
// jbsp_pkg
// Shared types, constants and the bit spreading function of the joybus bit
// symbol packer.
// ----------------------------------------------------------------------------
package jbsp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned HALF_W     = 2 * BYTE_W;
   localparam int unsigned WORD_W     = 2 * HALF_W;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned LEVEL_W    = $clog2(FIFO_DEPTH + 1);

   // End-bit symbol: enable and data both set.
   localparam logic [1:0] END_SYMBOL = 2'b11;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              is_last_byte;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] symbol_word;
      logic              is_final_word;
   } rsp_type;

   // Words produced for one item, in order; count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
   } fifo_status_type;

   // Each bit, most significant first, becomes a symbol {1, bit}; the first
   // symbol lands in the lowest two bits.
   function automatic logic [HALF_W-1:0] spread_byte(input logic [BYTE_W-1:0] b);
      logic [HALF_W-1:0] img;
      img = '0;
      for (int j = 0; j < BYTE_W; j++) begin
         img[2*j+1] = 1'b1;
         img[2*j]   = b[BYTE_W-1-j];
      end
      return img;
   endfunction

endpackage

>>> sv/jbsp_encoder.sv
// ----------------------------------------------------------------------------
// jbsp_encoder
// Input register, pending half state and the word assembly for one item.
// ----------------------------------------------------------------------------
module jbsp_encoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  jbsp_pkg::req_type   req_data,
   input  logic                space_ok,
   output jbsp_pkg::push_type  push
);

   logic                            stage_valid_ff, stage_valid_in;
   jbsp_pkg::req_type               stage_ff;
   logic                            pend_ff, pend_in;
   logic [jbsp_pkg::HALF_W-1:0]     pending_ff, pending_in;
   logic [jbsp_pkg::HALF_W-1:0]     img;
   logic                            fire;

   assign fire      = stage_valid_ff && space_ok;
   assign req_ready = !stage_valid_ff || fire;
   assign img       = jbsp_pkg::spread_byte(stage_ff.data_byte);

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
      end else if (fire) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      pend_in    = pend_ff;
      pending_in = pending_ff;
      push       = '0;
      if (fire) begin
         if (!pend_ff) begin
            if (!stage_ff.is_last_byte) begin
               pend_in    = 1'b1;
               pending_in = img;
            end else begin
               // Odd byte count: the end bit fills the free upper half.
               push.count                     = 2'd1;
               push.first.symbol_word         = {{(jbsp_pkg::HALF_W-2){1'b0}},
                                                 jbsp_pkg::END_SYMBOL, img};
               push.first.is_final_word       = 1'b1;
            end
         end else begin
            pend_in                   = 1'b0;
            pending_in                = '0;
            push.first.symbol_word    = {img, pending_ff};
            push.first.is_final_word  = 1'b0;
            if (stage_ff.is_last_byte) begin
               // Even byte count: the end bit goes into an extra word.
               push.count                = 2'd2;
               push.second.symbol_word   = {{(jbsp_pkg::WORD_W-2){1'b0}},
                                            jbsp_pkg::END_SYMBOL};
               push.second.is_final_word = 1'b1;
            end else begin
               push.count = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         pend_ff        <= 1'b0;
         pending_ff     <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         pend_ff        <= pend_in;
         pending_ff     <= pending_in;
      end
      if (req_ready && req_valid) begin
         stage_ff <= req_data;
      end
   end

endmodule

>>> sv/jbsp_rsp_fifo.sv
// ----------------------------------------------------------------------------
// jbsp_rsp_fifo
// Small result queue that takes up to two words per cycle and hands out one.
// ----------------------------------------------------------------------------
module jbsp_rsp_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  jbsp_pkg::push_type         push,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output jbsp_pkg::rsp_type          rsp_data,
   output jbsp_pkg::fifo_status_type  status
);

   jbsp_pkg::rsp_type                 mem [jbsp_pkg::FIFO_DEPTH];
   logic [jbsp_pkg::FIFO_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [jbsp_pkg::FIFO_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [jbsp_pkg::LEVEL_W-1:0]      level_ff, level_in;
   logic [jbsp_pkg::FIFO_AW-1:0]      wr_next;
   logic                              pop;

   assign rsp_valid    = (level_ff != '0);
   assign rsp_data     = mem[rd_ptr_ff];
   assign pop          = rsp_valid && rsp_ready;
   assign status.level = level_ff;
   assign wr_next      = wr_ptr_ff + jbsp_pkg::FIFO_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + jbsp_pkg::FIFO_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + jbsp_pkg::FIFO_AW'(pop);
      level_in  = level_ff + jbsp_pkg::LEVEL_W'(push.count)
                  - jbsp_pkg::LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

endmodule

>>> sv/joybus_bit_symbol_packer.sv
// ----------------------------------------------------------------------------
// joybus_bit_symbol_packer
// Spreads reply bytes into 2-bit line symbols and packs them into 32-bit words.
// ----------------------------------------------------------------------------
// One byte per cycle is taken into an input register, as the queue allows;
// from there, once the queue has room for two words, it is turned into a 16-bit
// symbol image and, paired with the earlier byte, pushes zero, one or two words
// into a four-entry result queue. A new item is accepted in every cycle as long
// as the queue holds at most two words, so the sustained rate is one item per
// cycle; a last byte that closes an even count yields two words and the output
// side then sets the pace at one word per cycle.
module joybus_bit_symbol_packer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  jbsp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output jbsp_pkg::rsp_type  rsp_data
);

   jbsp_pkg::push_type         push;
   jbsp_pkg::fifo_status_type  status;
   logic                       space_ok;

   assign space_ok = (status.level <= jbsp_pkg::LEVEL_W'(jbsp_pkg::FIFO_DEPTH - 2));

   jbsp_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .space_ok  (space_ok),
      .push      (push)
   );

   jbsp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // The queue never overflows.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      status.level <= jbsp_pkg::LEVEL_W'(jbsp_pkg::FIFO_DEPTH))
      else $error("result queue level exceeds its depth");

   // A second word from one item is always the final word.
   a_second_final: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.second.is_final_word && !push.first.is_final_word)
      else $error("second word of an item is not the final word");

   // Words are only pushed when the queue has room for two.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space_ok)
      else $error("word pushed without queue room");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

>>> tb/jbsp_word_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jbsp_word_checker
// Watches both channels of the joybus bit symbol packer, predicts the packed
// symbol words for every accepted byte and compares them with the words the
// block hands out, oldest first.
// ----------------------------------------------------------------------------
module jbsp_word_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  jbsp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  jbsp_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                words_outstanding,
   output int                words_checked,
   output int                messages_closed
);

   jbsp_pkg::rsp_type                words_due[$];
   logic [jbsp_pkg::HALF_W-1:0]      held_half;
   logic                             half_held;

   // Bit i of the byte is sent as symbol 7-i, so it lands in bits 15-2i and
   // 14-2i, with the enable bit above the data bit.
   function automatic logic [jbsp_pkg::HALF_W-1:0] symbol_image(
      input logic [jbsp_pkg::BYTE_W-1:0] b);
      logic [jbsp_pkg::HALF_W-1:0] img;
      int                          i;
      img = '0;
      for (i = 0; i < jbsp_pkg::BYTE_W; i++)
         img[jbsp_pkg::HALF_W-1-2*i -: 2] = {1'b1, b[i]};
      return img;
   endfunction

   task automatic predict_words(input jbsp_pkg::req_type item);
      logic [jbsp_pkg::HALF_W-1:0] img;
      jbsp_pkg::rsp_type           w;
      img = symbol_image(item.data_byte);
      if (!half_held) begin
         if (!item.is_last_byte) begin
            held_half = img;
            half_held = 1'b1;
         end else begin
            // Odd byte count: the end bit fills the free upper half.
            w.symbol_word   = {{(jbsp_pkg::HALF_W-2){1'b0}}, jbsp_pkg::END_SYMBOL, img};
            w.is_final_word = 1'b1;
            words_due.push_back(w);
         end
      end else begin
         w.symbol_word   = {img, held_half};
         w.is_final_word = 1'b0;
         words_due.push_back(w);
         held_half = '0;
         half_held = 1'b0;
         if (item.is_last_byte) begin
            // Even byte count: the end bit needs a word of its own.
            w.symbol_word   = {{(jbsp_pkg::WORD_W-2){1'b0}}, jbsp_pkg::END_SYMBOL};
            w.is_final_word = 1'b1;
            words_due.push_back(w);
         end
      end
   endtask

   always @(posedge clock) begin
      jbsp_pkg::rsp_type want;
      if (reset) begin
         words_due.delete();
         held_half       = '0;
         half_held       = 1'b0;
         mismatch_count  = 0;
         words_checked   = 0;
         messages_closed = 0;
      end else begin
         // A word at the output cannot stem from a byte taken at this same edge,
         // so the output is checked before the new byte is predicted.
         if (rsp_valid && rsp_ready) begin
            if (words_due.size() == 0) begin
               $error("unexpected word: symbol_word %h, is_final_word %b",
                      rsp_data.symbol_word, rsp_data.is_final_word);
               mismatch_count++;
            end else begin
               want = words_due.pop_front();
               if (rsp_data.symbol_word !== want.symbol_word) begin
                  $error("symbol_word: expected %h, got %h",
                         want.symbol_word, rsp_data.symbol_word);
                  mismatch_count++;
               end
               if (rsp_data.is_final_word !== want.is_final_word) begin
                  $error("is_final_word: expected %b, got %b",
                         want.is_final_word, rsp_data.is_final_word);
                  mismatch_count++;
               end
               words_checked++;
               if (want.is_final_word)
                  messages_closed++;
            end
         end
         if (req_valid && req_ready)
            predict_words(req_data);
      end
      words_outstanding = words_due.size();
   end

endmodule

>>> tb/tb_joybus_bit_symbol_packer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joybus_bit_symbol_packer
// Drives reply messages of random length and content into the symbol packer,
// with random idle cycles on both sides and one long output stall, and leaves
// the checking of every packed word to the word checker.
// ----------------------------------------------------------------------------
module tb_joybus_bit_symbol_packer;

   localparam int BYTE_TARGET = 1750;
   localparam int HOLD_CYCLES = 120;
   localparam int IDLE_PCT    = 11;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   jbsp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   jbsp_pkg::rsp_type rsp_data;

   int      mismatch_count;
   int      words_outstanding;
   int      words_checked;
   int      messages_closed;

   int      bytes_sent;
   int      messages_sent;
   int      holds_done;
   logic    hold_request;
   logic    hold_taken;
   logic    sender_idles;
   logic    receiver_stalls;

   joybus_bit_symbol_packer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   jbsp_word_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding),
      .words_checked     (words_checked),
      .messages_closed   (messages_closed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one byte and returns at the edge where it is accepted; valid is
   // left high so that a following item goes out without a gap.
   task automatic send_byte(input logic [jbsp_pkg::BYTE_W-1:0] b, input logic last);
      while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, is_last_byte: last};
      do
         @(posedge clock);
      while (!(req_valid && req_ready));
      bytes_sent++;
      if (last)
         messages_sent++;
   endtask

   function automatic logic [jbsp_pkg::BYTE_W-1:0] pick_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return '1;
      else
         return jbsp_pkg::BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic send_message(input int len);
      int k;
      for (k = 0; k < len; k++)
         send_byte(pick_byte(), k == len - 1);
   endtask

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin
      rsp_ready  = 1'b0;
      holds_done = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            rsp_ready <= !(receiver_stalls && $urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   initial begin
      int len;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      bytes_sent      = 0;
      messages_sent   = 0;
      hold_request    = 1'b0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Single-byte messages, even and odd lengths, and the byte extremes.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'hA5, 1'b1);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b1);

      while (bytes_sent < BYTE_TARGET) begin
         if (bytes_sent >= 500 && holds_done == 0 && !hold_request) begin
            // Stall the output for a long stretch while a long message keeps
            // coming, so that the result queue fills and the input backs up.
            hold_request = 1'b1;
            sender_idles = 1'b0;
            send_message(40);
         end else begin
            sender_idles    = !(bytes_sent >= 1000 && bytes_sent < 1300);
            receiver_stalls = sender_idles;
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                             : $urandom_range(5, 24);
            send_message(len);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (words_outstanding != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes in %0d messages; %0d words checked, %0d of them final.",
               bytes_sent, messages_sent, words_checked, messages_closed);
      $display("The output was held off %0d time(s) for %0d cycles.",
               holds_done, HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("tb_joybus_bit_symbol_packer: clean");
      else
         $display("tb_joybus_bit_symbol_packer: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d words still due.", words_outstanding);
      $display("tb_joybus_bit_symbol_packer: errors");
      $finish;
   end

endmodule
